FILE: rtl/gpsi_pkg.sv
package gpsi_pkg;

   // field widths of the request and response beats
   localparam int CMD_W      = 1;
   localparam int ROW_W      = 10;
   localparam int WIDX_W     = 4;
   localparam int DATA_W     = 64;
   localparam int NODE_W     = 10;
   localparam int COUNT_W    = 11;
   localparam int VALUE_W    = 40;

   // control registers
   localparam int SEL_W      = 4;
   localparam int NCNT_W     = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 11;

   // default geometry
   localparam int MAX_NODES_DEF = 1024;
   localparam int WORD_BITS_DEF = 64;

   // divide / root datapath
   localparam int FRAC_W = 16;
   localparam int NUM_W  = 56;
   localparam int DEN_W  = 22;
   localparam int ROOT_W = NUM_W / 2;

   localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_SELECT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT   = 1'b1;

   localparam logic [SEL_W-1:0] IDX_COMMON        = 4'd0;
   localparam logic [SEL_W-1:0] IDX_JACCARD       = 4'd1;
   localparam logic [SEL_W-1:0] IDX_NORM_JACCARD  = 4'd2;
   localparam logic [SEL_W-1:0] IDX_COSINE        = 4'd3;
   localparam logic [SEL_W-1:0] IDX_HUB_PROMOTED  = 4'd4;
   localparam logic [SEL_W-1:0] IDX_HUB_DEPRESSED = 4'd5;
   localparam logic [SEL_W-1:0] IDX_LHN           = 4'd6;
   localparam logic [SEL_W-1:0] IDX_PREF_ATTACH   = 4'd7;
   localparam logic [SEL_W-1:0] IDX_SORENSEN      = 4'd8;
   localparam logic [SEL_W-1:0] IDX_SALTON        = 4'd9;
   localparam logic [SEL_W-1:0] IDX_AVG_DEGREE    = 4'd10;

   localparam logic [SEL_W-1:0]  SEL_RESET  = IDX_JACCARD;
   localparam logic [NCNT_W-1:0] NCNT_RESET = 11'd1024;

   typedef struct packed {
      logic start;
      logic root_mode;
   } arith_cmd_type;

endpackage

FILE: rtl/gpsi_if.sv
interface gpsi_req_if;
   import gpsi_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [ROW_W-1:0]    row_index;
   logic [WIDX_W-1:0]   word_index;
   logic [DATA_W-1:0]   word_data;
   logic [NODE_W-1:0]   node_a;
   logic [NODE_W-1:0]   node_b;

   modport source (output valid, cmd, row_index, word_index, word_data, node_a, node_b,
                   input ready);
   modport sink   (input valid, cmd, row_index, word_index, word_data, node_a, node_b,
                   output ready);
endinterface

interface gpsi_rsp_if;
   import gpsi_pkg::*;
   logic                valid;
   logic                ready;
   logic [COUNT_W-1:0]  common_count;
   logic [COUNT_W-1:0]  union_count;
   logic [COUNT_W-1:0]  degree_a_half;
   logic [COUNT_W-1:0]  degree_b_half;
   logic [VALUE_W-1:0]  index_value;
   logic                divide_by_zero;

   modport source (output valid, common_count, union_count, degree_a_half, degree_b_half,
                   index_value, divide_by_zero, input ready);
   modport sink   (input valid, common_count, union_count, degree_a_half, degree_b_half,
                   index_value, divide_by_zero, output ready);
endinterface

FILE: rtl/graph_pair_similarity_index_top.sv
// neighborhood similarity of a node pair over a stored adjacency matrix
//
// req_ch carries one beat per command. cmd write stores word_data (low WORD_BITS
// bits) at row_index / word_index and answers at once with an all-zero rsp beat.
// cmd query walks rows node_a and node_b over node_count columns, counts common,
// union and per-row populations, then forms the index picked by index_select.
// csr_we / csr_index / csr_wdata write index_select (0) and node_count (1).
//
// a write is answered straight from the output register. a query walks the
// row words of both nodes, drains the last read, forms the two products, sets
// up the index, then runs the shared restoring divider when the index divides
// by a nonzero divisor, and the unit again in root mode for cosine and salton.
// the divider / root unit retires one bit per cycle.
// one command is in flight at a time; req_ch.ready is low meanwhile.
//
// reset: after reset the block sweeps the matrix to zero, one word a cycle, for
// all MAX_NODES*MAX_NODES/WORD_BITS words (16384 by default), with req_ch.ready low.
// csr writes are taken during the sweep.
// a stalled rsp beat holds in the output register; a finished query waits in the
// done state for the slot and no new command is taken until it is free.
module graph_pair_similarity_index_top #(
   parameter int MAX_NODES = gpsi_pkg::MAX_NODES_DEF,
   parameter int WORD_BITS = gpsi_pkg::WORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   gpsi_req_if.sink                          req_ch,
   gpsi_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [gpsi_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gpsi_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gpsi_pkg::*;

   localparam int WPR     = MAX_NODES / WORD_BITS;
   localparam int DEPTH   = MAX_NODES * WPR;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int WCNT_W  = $clog2(WPR + 1);
   localparam int POP_W   = $clog2(WORD_BITS + 1);
   localparam int COL_W   = (($clog2(MAX_NODES + 1) > NCNT_W) ?
                             $clog2(MAX_NODES + 1) : NCNT_W) + 1;
   localparam int PROD_W  = 2 * COUNT_W + 1;

   // sequencer states
   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] ST_CLEAR  = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE   = 4'd1;
   localparam logic [ST_W-1:0] ST_WALK   = 4'd2;
   localparam logic [ST_W-1:0] ST_DRAIN  = 4'd3;
   localparam logic [ST_W-1:0] ST_MUL_AB = 4'd4;
   localparam logic [ST_W-1:0] ST_MUL_C  = 4'd5;
   localparam logic [ST_W-1:0] ST_SETUP  = 4'd6;
   localparam logic [ST_W-1:0] ST_DIV    = 4'd7;
   localparam logic [ST_W-1:0] ST_ROOT   = 4'd8;
   localparam logic [ST_W-1:0] ST_DONE   = 4'd9;

   logic [ST_W-1:0]      state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [SEL_W-1:0]     sel_ff, sel_in;
   logic [NCNT_W-1:0]    ncnt_ff, ncnt_in;
   logic [NODE_W-1:0]    node_a_ff, node_a_in;
   logic [NODE_W-1:0]    node_b_ff, node_b_in;
   logic                 a_ok_ff, a_ok_in;
   logic                 b_ok_ff, b_ok_in;
   logic [WCNT_W-1:0]    w_ff, w_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [WORD_BITS-1:0] mask_ff, mask_in;
   logic [COUNT_W-1:0]   c_ff, c_in;
   logic [COUNT_W-1:0]   u_ff, u_in;
   logic [COUNT_W-1:0]   pa_ff, pa_in;
   logic [COUNT_W-1:0]   pb_ff, pb_in;
   logic [DEN_W-1:0]     prod_ab_ff, prod_ab_in;
   logic [PROD_W-1:0]    prod_c_ff, prod_c_in;
   logic                 need_root_ff, need_root_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic                 dz_ff, dz_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [COUNT_W-1:0]   out_c_ff, out_c_in;
   logic [COUNT_W-1:0]   out_u_ff, out_u_in;
   logic [COUNT_W-1:0]   out_pa_ff, out_pa_in;
   logic [COUNT_W-1:0]   out_pb_ff, out_pb_in;
   logic [VALUE_W-1:0]   out_val_ff, out_val_in;
   logic                 out_dz_ff, out_dz_in;

   // memory port signals
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;
   logic [ADDR_W-1:0]    raddr_a, raddr_b;
   logic [WORD_BITS-1:0] rdata_a, rdata_b;

   // walk bookkeeping
   logic [COL_W-1:0]     n_eff;
   logic [COL_W-1:0]     base;
   logic [COL_W-1:0]     left;
   logic                 last_issue;
   logic [WORD_BITS-1:0] mask_nxt;
   logic [WORD_BITS-1:0] xa, xb;
   logic [POP_W-1:0]     pop_c, pop_u, pop_a, pop_b;

   // handshake
   logic                 slot_free;
   logic                 accept;
   logic                 wr_ok;

   // multiplier and index setup
   logic [COUNT_W-1:0]   mul_x;
   logic [COUNT_W:0]     mul_y;
   logic [PROD_W-1:0]    mul_p;
   logic [COUNT_W:0]     sum_ab;
   logic [COUNT_W-1:0]   mn, mx;
   logic                 set_dz, set_div, set_root;
   logic [VALUE_W-1:0]   set_val;
   logic [NUM_W-1:0]     set_num;
   logic [DEN_W-1:0]     set_den;

   // shared divide / root unit
   arith_cmd_type        arith_cmd;
   logic [NUM_W-1:0]     arith_num;
   logic                 arith_done;
   logic [NUM_W-1:0]     arith_result;

   gpsi_adj_mem #(
      .DEPTH (DEPTH),
      .WIDTH (WORD_BITS)
   ) u_mem (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   gpsi_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (arith_cmd),
      .num    (arith_num),
      .den    (set_den),
      .done   (arith_done),
      .result (arith_result)
   );

   // output slot is free when empty or draining this cycle
   assign slot_free    = ~rsp_vld_ff | rsp_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE) & slot_free;
   assign accept       = req_ch.valid & req_ch.ready;
   assign wr_ok        = (32'(req_ch.row_index) < MAX_NODES) &&
                         (32'(req_ch.word_index) < WPR);

   // node_count saturates at the matrix size
   assign n_eff = (32'(ncnt_ff) > MAX_NODES) ? COL_W'(MAX_NODES) : COL_W'(ncnt_ff);
   assign base  = COL_W'(w_ff) * COL_W'(WORD_BITS);
   assign left  = n_eff - base;
   assign last_issue = (COL_W'(base + COL_W'(WORD_BITS)) >= n_eff) ||
                       (w_ff == WCNT_W'(WPR - 1));

   // partial last word keeps only the columns below n
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         mask_nxt[i] = (COL_W'(i) < left);
      end
   end

   assign raddr_a = ADDR_W'(ADDR_W'(node_a_ff) * ADDR_W'(WPR)) + ADDR_W'(w_ff);
   assign raddr_b = ADDR_W'(ADDR_W'(node_b_ff) * ADDR_W'(WPR)) + ADDR_W'(w_ff);

   // write port: clearing sweep or a write beat
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_addr_ff;
         mem_wdata = '0;
      end else begin
         mem_we    = accept && (req_ch.cmd == CMD_WRITE) && wr_ok;
         mem_waddr = ADDR_W'(ADDR_W'(req_ch.row_index) * ADDR_W'(WPR)) +
                     ADDR_W'(req_ch.word_index);
         mem_wdata = req_ch.word_data[WORD_BITS-1:0];
      end
   end

   // populations of the word pair that came back from memory
   assign xa = rdata_a & mask_ff & {WORD_BITS{a_ok_ff}};
   assign xb = rdata_b & mask_ff & {WORD_BITS{b_ok_ff}};

   always_comb begin
      pop_c = '0;
      pop_u = '0;
      pop_a = '0;
      pop_b = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         pop_c = pop_c + POP_W'(xa[i] & xb[i]);
         pop_u = pop_u + POP_W'(xa[i] | xb[i]);
         pop_a = pop_a + POP_W'(xa[i]);
         pop_b = pop_b + POP_W'(xb[i]);
      end
   end

   assign sum_ab = {1'b0, pa_ff} + {1'b0, pb_ff};
   assign mn     = (pa_ff < pb_ff) ? pa_ff : pb_ff;
   assign mx     = (pa_ff < pb_ff) ? pb_ff : pa_ff;

   // one multiplier, operands picked by the sequencer
   always_comb begin
      if (state_ff == ST_MUL_AB) begin
         mul_x = pa_ff;
         mul_y = {1'b0, pb_ff};
      end else begin
         mul_x = c_ff;
         mul_y = (sel_ff == IDX_NORM_JACCARD) ? sum_ab : {1'b0, c_ff};
      end
      mul_p = {{(COUNT_W + 1){1'b0}}, mul_x} * {{COUNT_W{1'b0}}, mul_y};
   end

   // pick numerator and divisor of the selected index
   always_comb begin
      set_dz   = 1'b0;
      set_div  = 1'b0;
      set_root = 1'b0;
      set_val  = '0;
      set_num  = '0;
      set_den  = '0;
      unique case (sel_ff)
         IDX_COMMON: begin
            set_val = VALUE_W'(c_ff) << FRAC_W;
         end
         IDX_JACCARD: begin
            set_dz  = (u_ff == '0);
            set_div = 1'b1;
            set_num = NUM_W'(c_ff) << FRAC_W;
            set_den = DEN_W'(u_ff);
         end
         IDX_NORM_JACCARD: begin
            set_dz  = (pa_ff == '0) || (pb_ff == '0);
            set_div = 1'b1;
            set_num = NUM_W'(prod_c_ff) << FRAC_W;
            set_den = prod_ab_ff;
         end
         IDX_COSINE: begin
            set_dz   = (u_ff == '0);
            set_div  = 1'b1;
            set_root = 1'b1;
            set_num  = NUM_W'(prod_c_ff) << 32;
            set_den  = DEN_W'(u_ff);
         end
         IDX_HUB_PROMOTED: begin
            set_dz  = (mn == '0);
            set_div = 1'b1;
            set_num = NUM_W'(c_ff) << (FRAC_W + 1);
            set_den = DEN_W'(mn);
         end
         IDX_HUB_DEPRESSED: begin
            set_dz  = (mx == '0);
            set_div = 1'b1;
            set_num = NUM_W'(c_ff) << (FRAC_W + 1);
            set_den = DEN_W'(mx);
         end
         IDX_LHN: begin
            set_dz  = (pa_ff == '0) || (pb_ff == '0);
            set_div = 1'b1;
            set_num = NUM_W'(c_ff) << (FRAC_W + 2);
            set_den = prod_ab_ff;
         end
         IDX_PREF_ATTACH: begin
            set_val = VALUE_W'(prod_ab_ff) << (FRAC_W - 2);
         end
         IDX_SORENSEN: begin
            set_dz  = (sum_ab == '0);
            set_div = 1'b1;
            set_num = NUM_W'(c_ff) << (FRAC_W + 2);
            set_den = DEN_W'(sum_ab);
         end
         IDX_SALTON: begin
            // 4*c*c scaled by 2^32 is c*c scaled by 2^34
            set_dz   = (pa_ff == '0) || (pb_ff == '0);
            set_div  = 1'b1;
            set_root = 1'b1;
            set_num  = NUM_W'(prod_c_ff) << 34;
            set_den  = prod_ab_ff;
         end
         IDX_AVG_DEGREE: begin
            set_val = VALUE_W'(sum_ab) << (FRAC_W - 1);
         end
         default: begin
            set_val = '0;
         end
      endcase
   end

   // divide starts from setup, root restarts on the quotient
   always_comb begin
      arith_cmd.start     = 1'b0;
      arith_cmd.root_mode = 1'b0;
      arith_num           = set_num;
      if (state_ff == ST_SETUP) begin
         arith_cmd.start = set_div & ~set_dz;
      end else if ((state_ff == ST_DIV) && arith_done && need_root_ff) begin
         arith_cmd.start     = 1'b1;
         arith_cmd.root_mode = 1'b1;
         arith_num           = arith_result;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      sel_in       = sel_ff;
      ncnt_in      = ncnt_ff;
      node_a_in    = node_a_ff;
      node_b_in    = node_b_ff;
      a_ok_in      = a_ok_ff;
      b_ok_in      = b_ok_ff;
      w_in         = w_ff;
      rd_vld_in    = 1'b0;
      mask_in      = mask_ff;
      c_in         = c_ff;
      u_in         = u_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      prod_ab_in   = prod_ab_ff;
      prod_c_in    = prod_c_ff;
      need_root_in = need_root_ff;
      val_in       = val_ff;
      dz_in        = dz_ff;
      rsp_vld_in   = rsp_vld_ff & ~rsp_ch.ready;
      out_c_in     = out_c_ff;
      out_u_in     = out_u_ff;
      out_pa_in    = out_pa_ff;
      out_pb_in    = out_pb_ff;
      out_val_in   = out_val_ff;
      out_dz_in    = out_dz_ff;

      // csr writes
      if (csr_we) begin
         if (csr_index == CSR_INDEX_SELECT) begin
            sel_in = csr_wdata[SEL_W-1:0];
         end else begin
            ncnt_in = csr_wdata[NCNT_W-1:0];
         end
      end

      // accumulate the word pair read last cycle
      if (rd_vld_ff) begin
         c_in  = c_ff  + COUNT_W'(pop_c);
         u_in  = u_ff  + COUNT_W'(pop_u);
         pa_in = pa_ff + COUNT_W'(pop_a);
         pb_in = pb_ff + COUNT_W'(pop_b);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_ch.cmd == CMD_WRITE) begin
                  // write beat answers with all-zero fields
                  rsp_vld_in = 1'b1;
                  out_c_in   = '0;
                  out_u_in   = '0;
                  out_pa_in  = '0;
                  out_pb_in  = '0;
                  out_val_in = '0;
                  out_dz_in  = 1'b0;
               end else begin
                  node_a_in = req_ch.node_a;
                  node_b_in = req_ch.node_b;
                  a_ok_in   = (32'(req_ch.node_a) < MAX_NODES);
                  b_ok_in   = (32'(req_ch.node_b) < MAX_NODES);
                  w_in      = '0;
                  c_in      = '0;
                  u_in      = '0;
                  pa_in     = '0;
                  pb_in     = '0;
                  state_in  = (n_eff == '0) ? ST_MUL_AB : ST_WALK;
               end
            end
         end
         ST_WALK: begin
            rd_vld_in = 1'b1;
            mask_in   = mask_nxt;
            w_in      = w_ff + WCNT_W'(1);
            if (last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MUL_AB;
         end
         ST_MUL_AB: begin
            prod_ab_in = mul_p[DEN_W-1:0];
            state_in   = ST_MUL_C;
         end
         ST_MUL_C: begin
            prod_c_in = mul_p;
            state_in  = ST_SETUP;
         end
         ST_SETUP: begin
            dz_in        = set_dz;
            val_in       = set_val;
            need_root_in = set_root;
            if (set_div && !set_dz) begin
               state_in = ST_DIV;
            end else begin
               if (set_dz) begin
                  val_in = '0;
               end
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (arith_done) begin
               if (need_root_ff) begin
                  state_in = ST_ROOT;
               end else begin
                  val_in   = arith_result[VALUE_W-1:0];
                  state_in = ST_DONE;
               end
            end
         end
         ST_ROOT: begin
            if (arith_done) begin
               val_in   = arith_result[VALUE_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_vld_in = 1'b1;
               out_c_in   = c_ff;
               out_u_in   = u_ff;
               out_pa_in  = pa_ff;
               out_pb_in  = pb_ff;
               out_val_in = val_ff;
               out_dz_in  = dz_ff;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         sel_ff      <= SEL_RESET;
         ncnt_ff     <= NCNT_RESET;
         rd_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         sel_ff      <= sel_in;
         ncnt_ff     <= ncnt_in;
         rd_vld_ff   <= rd_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
      node_a_ff    <= node_a_in;
      node_b_ff    <= node_b_in;
      a_ok_ff      <= a_ok_in;
      b_ok_ff      <= b_ok_in;
      w_ff         <= w_in;
      mask_ff      <= mask_in;
      c_ff         <= c_in;
      u_ff         <= u_in;
      pa_ff        <= pa_in;
      pb_ff        <= pb_in;
      prod_ab_ff   <= prod_ab_in;
      prod_c_ff    <= prod_c_in;
      need_root_ff <= need_root_in;
      val_ff       <= val_in;
      dz_ff        <= dz_in;
      out_c_ff     <= out_c_in;
      out_u_ff     <= out_u_in;
      out_pa_ff    <= out_pa_in;
      out_pb_ff    <= out_pb_in;
      out_val_ff   <= out_val_in;
      out_dz_ff    <= out_dz_in;
   end

   // response beat
   assign rsp_ch.valid          = rsp_vld_ff;
   assign rsp_ch.common_count   = out_c_ff;
   assign rsp_ch.union_count    = out_u_ff;
   assign rsp_ch.degree_a_half  = out_pa_ff;
   assign rsp_ch.degree_b_half  = out_pb_ff;
   assign rsp_ch.index_value    = out_val_ff;
   assign rsp_ch.divide_by_zero = out_dz_ff;
endmodule

FILE: rtl/gpsi_adj_mem.sv
module gpsi_adj_mem #(
   parameter int DEPTH = 16384,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end
endmodule

FILE: rtl/gpsi_arith.sv
module gpsi_arith (
   input  logic                          clock,
   input  logic                          reset,
   input  gpsi_pkg::arith_cmd_type       cmd,
   input  logic [gpsi_pkg::NUM_W-1:0]    num,
   input  logic [gpsi_pkg::DEN_W-1:0]    den,
   output logic                          done,
   output logic [gpsi_pkg::NUM_W-1:0]    result
);
   import gpsi_pkg::*;

   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(NUM_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               mode_ff, mode_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [NUM_W-1:0]   acc_ff, acc_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [DEN_W-1:0]   den_ff, den_in;

   logic [REM_W-1:0]   trial_a;
   logic [REM_W-1:0]   trial_b;
   logic [REM_W:0]     diff;
   logic               fit;

   // one restoring step: a quotient bit or a root bit
   always_comb begin
      if (mode_ff) begin
         trial_a = {rem_ff[REM_W-3:0], acc_ff[NUM_W-1 -: 2]};
         trial_b = REM_W'({root_ff, 2'b01});
      end else begin
         trial_a = {rem_ff[REM_W-2:0], acc_ff[NUM_W-1]};
         trial_b = REM_W'(den_ff);
      end
      diff = {1'b0, trial_a} - {1'b0, trial_b};
      fit  = ~diff[REM_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      den_in  = den_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.root_mode;
         cnt_in  = cmd.root_mode ? CNT_W'(ROOT_W - 1) : CNT_W'(NUM_W - 1);
         acc_in  = num;
         rem_in  = '0;
         root_in = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = fit ? diff[REM_W-1:0] : trial_a;
         if (mode_ff) begin
            acc_in  = {acc_ff[NUM_W-3:0], 2'b00};
            root_in = {root_ff[ROOT_W-2:0], fit};
         end else begin
            acc_in = {acc_ff[NUM_W-2:0], fit};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      den_ff  <= den_in;
   end

   assign done   = done_ff;
   assign result = mode_ff ? NUM_W'(root_ff) : acc_ff;
endmodule

FILE: rtl/gpsi_checker.sv
module gpsi_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic [gpsi_pkg::CMD_W-1:0]     req_cmd,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [gpsi_pkg::COUNT_W-1:0]   common_count,
   input logic [gpsi_pkg::COUNT_W-1:0]   union_count,
   input logic [gpsi_pkg::COUNT_W-1:0]   degree_a_half,
   input logic [gpsi_pkg::VALUE_W-1:0]   index_value,
   input logic                           divide_by_zero
);
   import gpsi_pkg::*;

   // no beat right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp beat right after reset");

   // a write beat answers next cycle with zero fields
   a_write_answer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_WRITE) |=>
         rsp_valid && (common_count == '0) && (index_value == '0))
      else $error("write beat not answered with zero beat");

   // zero divisor forces zero value
   a_dz_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && divide_by_zero |-> (index_value == '0))
      else $error("divide_by_zero with nonzero value");

   // common never exceeds union or a row population
   a_counts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (common_count <= union_count) && (common_count <= degree_a_half))
      else $error("count relation broken");

   // stalled beat stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp beat dropped while stalled");
endmodule

bind graph_pair_similarity_index_top gpsi_checker u_gpsi_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_cmd        (req_ch.cmd),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .common_count   (rsp_ch.common_count),
   .union_count    (rsp_ch.union_count),
   .degree_a_half  (rsp_ch.degree_a_half),
   .index_value    (rsp_ch.index_value),
   .divide_by_zero (rsp_ch.divide_by_zero)
);

FILE: verif/graph_pair_similarity_index_top_tb.sv
module graph_pair_similarity_index_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gpsi_pkg::*;

   localparam int WORDS_PER_ROW = MAX_NODES_DEF / WORD_BITS_DEF;
   localparam int STALL_LIMIT   = 60000;   // sweep after reset plus long receiver hold
   localparam int N_RANDOM      = 1450;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   gpsi_req_if req_ch ();
   gpsi_rsp_if rsp_ch ();

   graph_pair_similarity_index_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch.sink),
      .rsp_ch   (rsp_ch.source),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   typedef struct packed {
      logic [COUNT_W-1:0] common;
      logic [COUNT_W-1:0] unio;
      logic [COUNT_W-1:0] pop_a;
      logic [COUNT_W-1:0] pop_b;
      logic [VALUE_W-1:0] value;
      logic               dz;
   } score_type;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [ROW_W-1:0]  row;
      logic [WIDX_W-1:0] widx;
      logic [DATA_W-1:0] data;
      logic [NODE_W-1:0] a;
      logic [NODE_W-1:0] b;
   } beat_type;

   // shadow copy of the matrix and registers
   logic [DATA_W-1:0] adj_shadow [MAX_NODES_DEF*WORDS_PER_ROW];
   logic [SEL_W-1:0]  sel_shadow;
   logic [NCNT_W-1:0] ncnt_shadow;

   score_type pending_scores[$];
   int     fail_count = 0;
   int     idle_cycles = 0;
   bit     rsp_hold = 1'b0;     // request a long receiver hold-off
   bit     no_idle = 1'b0;      // stretch with neither side idling
   bit     stim_done = 1'b0;

   function automatic int popcount64(logic [63:0] x);
      int n;
      n = 0;
      for (int i = 0; i < 64; i++) n += x[i];
      return n;
   endfunction

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   // similarity of a pair, or the all-zero answer of a write; updates the shadow
   function automatic score_type predict_similarity(beat_type bt);
      score_type s;
      logic [63:0] c, u, pa, pb, v, mn, mx, n, m, x, y;
      logic dz;
      s = '0;
      if (bt.cmd == CMD_WRITE) begin
         adj_shadow[bt.row * WORDS_PER_ROW + bt.widx] = bt.data;
         return s;
      end
      c = 0; u = 0; pa = 0; pb = 0; v = 0; dz = 0;
      n = (ncnt_shadow > MAX_NODES_DEF) ? MAX_NODES_DEF : ncnt_shadow;
      for (int w = 0; w < WORDS_PER_ROW; w++) begin
         if (w * 64 >= n) break;
         m = (n - w * 64 < 64) ? ((64'd1 << (n - w * 64)) - 1) : '1;
         x = adj_shadow[bt.a * WORDS_PER_ROW + w] & m;
         y = adj_shadow[bt.b * WORDS_PER_ROW + w] & m;
         c += popcount64(x & y);
         u += popcount64(x | y);
         pa += popcount64(x);
         pb += popcount64(y);
      end
      mn = (pa < pb) ? pa : pb;
      mx = (pa < pb) ? pb : pa;
      case (sel_shadow)
         IDX_COMMON: v = c << 16;
         IDX_JACCARD: if (u == 0) dz = 1; else v = (c << 16) / u;
         IDX_NORM_JACCARD:
            if (pa == 0 || pb == 0) dz = 1; else v = ((c * (pa + pb)) << 16) / (pa * pb);
         IDX_COSINE: if (u == 0) dz = 1; else v = isqrt(((c * c) << 32) / u);
         IDX_HUB_PROMOTED: if (mn == 0) dz = 1; else v = (c << 17) / mn;
         IDX_HUB_DEPRESSED: if (mx == 0) dz = 1; else v = (c << 17) / mx;
         IDX_LHN: if (pa == 0 || pb == 0) dz = 1; else v = (c << 18) / (pa * pb);
         IDX_PREF_ATTACH: v = (pa * pb) << 14;
         IDX_SORENSEN: if (pa + pb == 0) dz = 1; else v = (c << 18) / (pa + pb);
         IDX_SALTON:
            if (pa == 0 || pb == 0) dz = 1; else v = isqrt(((4 * c * c) << 32) / (pa * pb));
         IDX_AVG_DEGREE: v = (pa + pb) << 15;
         default: v = 0;
      endcase
      s.common = c[COUNT_W-1:0];
      s.unio   = u[COUNT_W-1:0];
      s.pop_a  = pa[COUNT_W-1:0];
      s.pop_b  = pb[COUNT_W-1:0];
      s.value  = dz ? '0 : v[VALUE_W-1:0];
      s.dz     = dz;
      return s;
   endfunction

   // register write, only while the block is idle
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INDEX_SELECT) sel_shadow = val[SEL_W-1:0];
      else ncnt_shadow = val[NCNT_W-1:0];
   endtask

   // drive one request beat and wait for it to be taken;
   // a typed row expects its given answer, every other beat the predictor's
   task automatic send_beat(beat_type bt, bit typed = 1'b0, score_type want = '0);
      score_type exp_s;
      while (!no_idle && $urandom_range(99) < 36) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.cmd <= bt.cmd;
      req_ch.row_index <= bt.row;
      req_ch.word_index <= bt.widx;
      req_ch.word_data <= bt.data;
      req_ch.node_a <= bt.a;
      req_ch.node_b <= bt.b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      exp_s = predict_similarity(bt);
      if (typed) exp_s = want;
      pending_scores.push_back(exp_s);
      @(negedge clock);
   endtask

   // stop offering and wait until every answer is back
   task automatic wait_empty;
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending_scores.size() != 0);
   endtask

   task automatic drain;
      wait_empty();
      repeat (120) @(negedge clock);   // margin over the longest query
   endtask

   function automatic beat_type wr_beat(int row, int widx, logic [63:0] d);
      beat_type bt;
      bt = '{cmd: CMD_WRITE, row: ROW_W'(row), widx: WIDX_W'(widx), data: d,
             a: '0, b: '0};
      return bt;
   endfunction

   function automatic beat_type q_beat(int a, int b);
      beat_type bt;
      bt = '{cmd: CMD_QUERY, row: '0, widx: '0, data: '0,
             a: NODE_W'(a), b: NODE_W'(b)};
      return bt;
   endfunction

   // random beat over a small node pool so queries hit written rows;
   // a few wide-range beats exercise every bit of every field
   function automatic beat_type rand_beat();
      beat_type bt;
      bit wide;
      wide = ($urandom_range(9) == 0);
      bt.cmd  = ($urandom_range(99) < 55) ? CMD_WRITE : CMD_QUERY;
      bt.row  = ROW_W'(wide ? $urandom_range(1023) : $urandom_range(7));
      bt.widx = WIDX_W'($urandom_range(15));
      case ($urandom_range(3))
         0: bt.data = {$urandom, $urandom};
         1: bt.data = {$urandom, $urandom} & {$urandom, $urandom};
         2: bt.data = '1;
         default: bt.data = {$urandom, $urandom} | {$urandom, $urandom};
      endcase
      bt.a = NODE_W'(wide ? $urandom_range(1023) : $urandom_range(7));
      bt.b = NODE_W'(wide ? $urandom_range(1023) : $urandom_range(7));
      return bt;
   endfunction

   // response side: random back-pressure plus one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (400) @(negedge clock);
            rsp_hold = 1'b0;
         end
         rsp_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 36);
      end
   end

   // compare each accepted response beat with the oldest prediction
   always @(posedge clock) begin
      score_type exp_s;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_scores.size() == 0) begin
            $error("response beat with no prediction waiting");
            fail_count++;
         end else begin
            exp_s = pending_scores.pop_front();
            if (rsp_ch.common_count !== exp_s.common) begin
               $error("common_count exp %0d got %0d", exp_s.common, rsp_ch.common_count);
               fail_count++;
            end
            if (rsp_ch.union_count !== exp_s.unio) begin
               $error("union_count exp %0d got %0d", exp_s.unio, rsp_ch.union_count);
               fail_count++;
            end
            if (rsp_ch.degree_a_half !== exp_s.pop_a) begin
               $error("degree_a_half exp %0d got %0d", exp_s.pop_a, rsp_ch.degree_a_half);
               fail_count++;
            end
            if (rsp_ch.degree_b_half !== exp_s.pop_b) begin
               $error("degree_b_half exp %0d got %0d", exp_s.pop_b, rsp_ch.degree_b_half);
               fail_count++;
            end
            if (rsp_ch.index_value !== exp_s.value) begin
               $error("index_value exp %0h got %0h", exp_s.value, rsp_ch.index_value);
               fail_count++;
            end
            if (rsp_ch.divide_by_zero !== exp_s.dz) begin
               $error("divide_by_zero exp %0b got %0b", exp_s.dz, rsp_ch.divide_by_zero);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no beat moving on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // directed table: beat, expected answer where obvious, flag for typed check
   typedef struct {
      beat_type  bt;
      score_type want;
      bit        typed;
   } row_type;

   row_type dir_tab[$];

   initial begin
      logic [SEL_W-1:0]  sel_list[$];
      logic [NCNT_W-1:0] ncnt_list[$];

      req_ch.valid = 1'b0;
      req_ch.cmd = CMD_WRITE;
      req_ch.row_index = '0;
      req_ch.word_index = '0;
      req_ch.word_data = '0;
      req_ch.node_a = '0;
      req_ch.node_b = '0;
      foreach (adj_shadow[i]) adj_shadow[i] = '0;
      sel_shadow = SEL_RESET;
      ncnt_shadow = NCNT_RESET;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part at reset settings (jaccard, 1024 nodes)
      // empty rows after reset: jaccard divides by zero
      dir_tab.push_back('{q_beat(0, 0), '{0, 0, 0, 0, 0, 1}, 1});
      dir_tab.push_back('{wr_beat(0, 0, '1), '0, 1});
      dir_tab.push_back('{wr_beat(1023, 15, '1), '0, 1});
      dir_tab.push_back('{wr_beat(1, 0, 64'h5555_5555_5555_5555), '0, 1});
      dir_tab.push_back('{wr_beat(1, 15, 64'h8000_0000_0000_0001), '0, 1});
      // identical full word: jaccard is exactly one
      dir_tab.push_back('{q_beat(0, 0), '{64, 64, 64, 64, 40'h10000, 0}, 1});
      dir_tab.push_back('{q_beat(0, 1), '0, 0});
      dir_tab.push_back('{q_beat(1023, 1), '0, 0});
      // disjoint rows: zero common over nonzero union
      dir_tab.push_back('{q_beat(0, 1023), '{0, 128, 64, 64, 0, 0}, 1});
      // pair with an empty row
      dir_tab.push_back('{q_beat(1023, 500), '{0, 64, 64, 0, 0, 0}, 1});
      dir_tab.push_back('{wr_beat(2, 7, {$urandom, $urandom}), '0, 1});
      dir_tab.push_back('{q_beat(2, 1), '0, 0});
      foreach (dir_tab[i]) send_beat(dir_tab[i].bt, dir_tab[i].typed, dir_tab[i].want);
      drain();

      // every index at several node counts, extremes included
      sel_list = '{IDX_COMMON, IDX_JACCARD, IDX_NORM_JACCARD, IDX_COSINE,
                   IDX_HUB_PROMOTED, IDX_HUB_DEPRESSED, IDX_LHN, IDX_PREF_ATTACH,
                   IDX_SORENSEN, IDX_SALTON, IDX_AVG_DEGREE, 4'd11, 4'd15};
      ncnt_list = '{11'd1024, 11'd0, 11'd1, 11'd65, 11'd2047, 11'd1000};
      foreach (ncnt_list[j]) begin
         write_csr(CSR_NODE_COUNT, ncnt_list[j]);
         foreach (sel_list[i]) begin
            write_csr(CSR_INDEX_SELECT, CSR_DATA_W'(sel_list[i]));
            send_beat(q_beat(0, 1));
            send_beat(q_beat(1, 1023));
            send_beat(q_beat(500, 0));
            drain();
         end
      end

      // random phases, each with its own settings
      for (int ph = 0; ph < 10; ph++) begin
         write_csr(CSR_INDEX_SELECT,
                   CSR_DATA_W'((ph < 9) ? $urandom_range(10) : $urandom_range(15)));
         write_csr(CSR_NODE_COUNT,
                   CSR_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(2047) :
                                                          $urandom_range(200)));
         no_idle = (ph == 4);
         if (ph == 2) rsp_hold = 1'b1;   // block fills up while input keeps coming
         for (int k = 0; k < N_RANDOM / 10; k++) begin
            send_beat(rand_beat());
            // pause until every answer is back once per phase
            if (k == 50) wait_empty();
         end
         no_idle = 1'b0;
         drain();
      end

      stim_done = 1'b1;
      drain();
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
